FILE: src/i2c_eeprom_master_macros.svh
// Assertion macros used by the checker file.
`ifndef I2C_EEPROM_MASTER_MACROS_SVH
`define I2C_EEPROM_MASTER_MACROS_SVH

// Plain concurrent assertion, clocked on the rising edge and off during reset.
`define I2CEE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion that is only checked on cycles where a result item is shown.
`define I2CEE_ASSERT_VLD(lbl, clk, rst_n, vld, prop, msg) \
	`I2CEE_ASSERT(lbl, clk, rst_n, (vld) |-> (prop), msg)

`endif

FILE: src/i2cee_pkg.sv
package i2cee_pkg;

	localparam int MAX_BURST_DEF = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [5:0] DEVICE_CODE_RST = 6'd40;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [15:0] WRITE_WAIT_RST = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_CODE = 2'd0,
		CFG_ACK_TIMEOUT = 2'd1,
		CFG_WRITE_WAIT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_READ    = 2'd1,
		MODE_RECOVER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SEG_DEVW = 2'd0,
		SEG_ADDR = 2'd1,
		SEG_DEVR = 2'd2,
		SEG_DATA = 2'd3
	} seg_t;

	typedef enum logic [4:0] {
		P_IDLE     = 5'd0,
		P_START1   = 5'd1,
		P_START2   = 5'd2,
		P_RS0      = 5'd3,
		P_TXLOW    = 5'd4,
		P_TXHIGH   = 5'd5,
		P_ACKLOW   = 5'd6,
		P_ACKHIGH  = 5'd7,
		P_RXLOW    = 5'd8,
		P_RXHIGH   = 5'd9,
		P_MACKLOW  = 5'd10,
		P_MACKHIGH = 5'd11,
		P_RECLOW   = 5'd12,
		P_RECHIGH  = 5'd13,
		P_STOP1    = 5'd14,
		P_STOP2    = 5'd15,
		P_STOP3    = 5'd16,
		P_WAIT     = 5'd17
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic       page;
		logic [7:0] byte_addr;
		logic [4:0] length;
		logic [7:0] wdata;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] rdata;
		logic       rdata_valid;
		logic       wdata_take;
		logic       done_res;
		logic       status;
	} res_t;

	typedef struct packed {
		logic [5:0]  device_code;
		logic [7:0]  ack_timeout;
		logic [15:0] write_wait_ticks;
	} cfg_t;

endpackage

FILE: src/i2cee_if.sv
interface i2cee_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/i2cee_cfg.sv
module i2cee_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2cee_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output i2cee_pkg::cfg_t                  cfg
);

	logic [5:0]  device_code_q;
	logic [7:0]  ack_timeout_q;
	logic [15:0] write_wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_code_q <= i2cee_pkg::DEVICE_CODE_RST;
			ack_timeout_q <= i2cee_pkg::ACK_TIMEOUT_RST;
			write_wait_q  <= i2cee_pkg::WRITE_WAIT_RST;
		end else if (cfg_we) begin
			unique case (i2cee_pkg::cfg_idx_t'(cfg_index))
				i2cee_pkg::CFG_DEVICE_CODE: device_code_q <= cfg_wdata[5:0];
				i2cee_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[7:0];
				i2cee_pkg::CFG_WRITE_WAIT:  write_wait_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg.device_code      = device_code_q;
	assign cfg.ack_timeout      = ack_timeout_q;
	assign cfg.write_wait_ticks = write_wait_q;

endmodule

FILE: src/i2cee_seq.sv
module i2cee_seq #(
	parameter int MAX_BURST = i2cee_pkg::MAX_BURST_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  i2cee_pkg::cmd_t   item,
	input  i2cee_pkg::cfg_t   cfg,
	output i2cee_pkg::res_t   res
);

	localparam int LEN_W = $clog2(MAX_BURST + 1);

	i2cee_pkg::phase_t phase_q, e_phase, n_phase;
	i2cee_pkg::seg_t   seg_q, e_seg, n_seg;
	logic [1:0]        mode_q, e_mode;
	logic              page_q, e_page;
	logic [7:0]        addr_q, e_addr;
	logic [LEN_W-1:0]  len_q, e_len, start_len;
	logic [3:0]        bit_q, e_bit, n_bit, bit_inc;
	logic [LEN_W-1:0]  byte_q, e_byte, n_byte;
	logic [LEN_W:0]    byte_inc;
	logic [7:0]        ack_q, e_ack, n_ack;
	logic [8:0]        ack_inc;
	logic [15:0]       pw_q, n_pw, pw_dec;
	logic [7:0]        shifter_q, n_shifter, tx_byte, rx_shift;
	logic              failed_q, e_failed, n_failed;
	logic              start, mode_ok, last_byte, ack_fail, wait_go;

	always_comb begin
		mode_ok = (item.mode == i2cee_pkg::MODE_WRITE) || (item.mode == i2cee_pkg::MODE_READ) ||
			(item.mode == i2cee_pkg::MODE_RECOVER);
		start = (phase_q == i2cee_pkg::P_IDLE) && item.cmd_valid && mode_ok;
		if (item.length == 5'd0) begin
			start_len = LEN_W'(1);
		end else if (32'(item.length) > 32'(MAX_BURST)) begin
			start_len = LEN_W'(MAX_BURST);
		end else begin
			start_len = LEN_W'(item.length);
		end
		e_phase  = start ? i2cee_pkg::P_START1 : phase_q;
		e_mode   = start ? item.mode : mode_q;
		e_page   = start ? item.page : page_q;
		e_addr   = start ? item.byte_addr : addr_q;
		e_len    = start ? start_len : len_q;
		e_bit    = start ? 4'd0 : bit_q;
		e_byte   = start ? '0 : byte_q;
		e_ack    = start ? 8'd0 : ack_q;
		e_seg    = start ? i2cee_pkg::SEG_DEVW : seg_q;
		e_failed = start ? 1'b0 : failed_q;
	end

	always_comb begin
		if (e_bit == 4'd0) begin
			case (e_seg)
				i2cee_pkg::SEG_DEVW: tx_byte = {cfg.device_code, e_page, 1'b0};
				i2cee_pkg::SEG_ADDR: tx_byte = e_addr;
				i2cee_pkg::SEG_DEVR: tx_byte = {cfg.device_code, e_page, 1'b1};
				default:             tx_byte = item.wdata;
			endcase
		end else begin
			tx_byte = shifter_q;
		end
		rx_shift  = {shifter_q[6:0], item.sda_in};
		bit_inc   = e_bit + 4'd1;
		byte_inc  = {1'b0, e_byte} + (LEN_W+1)'(1);
		last_byte = byte_inc >= {1'b0, e_len};
		ack_inc   = {1'b0, e_ack} + 9'd1;
		ack_fail  = ack_inc > {1'b0, cfg.ack_timeout};
		pw_dec    = (pw_q != 16'd0) ? pw_q - 16'd1 : pw_q;
		wait_go   = (e_mode == i2cee_pkg::MODE_WRITE) && !e_failed &&
			(cfg.write_wait_ticks != 16'd0);
	end

	// Next-state logic.
	always_comb begin
		n_phase   = e_phase;
		n_seg     = e_seg;
		n_bit     = e_bit;
		n_byte    = e_byte;
		n_ack     = e_ack;
		n_pw      = pw_q;
		n_shifter = shifter_q;
		n_failed  = e_failed;
		unique case (e_phase)
			i2cee_pkg::P_IDLE: ;
			i2cee_pkg::P_START1: n_phase = i2cee_pkg::P_START2;
			i2cee_pkg::P_START2: begin
				n_bit = 4'd0;
				if (e_mode == i2cee_pkg::MODE_RECOVER) begin
					n_phase = (e_seg == i2cee_pkg::SEG_DEVW) ? i2cee_pkg::P_RECLOW :
						i2cee_pkg::P_STOP1;
				end else begin
					n_phase = i2cee_pkg::P_TXLOW;
				end
			end
			i2cee_pkg::P_RS0: n_phase = i2cee_pkg::P_START1;
			i2cee_pkg::P_TXLOW: begin
				n_shifter = tx_byte;
				n_phase   = i2cee_pkg::P_TXHIGH;
			end
			i2cee_pkg::P_TXHIGH: begin
				n_shifter = {shifter_q[6:0], 1'b0};
				if (bit_inc >= 4'd8) begin
					n_bit   = 4'd0;
					n_phase = i2cee_pkg::P_ACKLOW;
				end else begin
					n_bit   = bit_inc;
					n_phase = i2cee_pkg::P_TXLOW;
				end
			end
			i2cee_pkg::P_ACKLOW: begin
				n_ack   = 8'd0;
				n_phase = i2cee_pkg::P_ACKHIGH;
			end
			i2cee_pkg::P_ACKHIGH: begin
				if (!item.sda_in) begin
					n_ack = 8'd0;
					case (e_seg)
						i2cee_pkg::SEG_DEVW: begin
							n_seg   = i2cee_pkg::SEG_ADDR;
							n_phase = i2cee_pkg::P_TXLOW;
						end
						i2cee_pkg::SEG_ADDR: begin
							if (e_mode == i2cee_pkg::MODE_READ) begin
								n_seg   = i2cee_pkg::SEG_DEVR;
								n_phase = i2cee_pkg::P_RS0;
							end else begin
								n_seg   = i2cee_pkg::SEG_DATA;
								n_byte  = '0;
								n_phase = i2cee_pkg::P_TXLOW;
							end
						end
						i2cee_pkg::SEG_DEVR: begin
							n_seg   = i2cee_pkg::SEG_DATA;
							n_byte  = '0;
							n_phase = i2cee_pkg::P_RXLOW;
						end
						default: begin
							n_byte  = byte_inc[LEN_W-1:0];
							n_phase = last_byte ? i2cee_pkg::P_STOP1 : i2cee_pkg::P_TXLOW;
						end
					endcase
				end else if (ack_fail) begin
					n_failed = 1'b1;
					n_phase  = i2cee_pkg::P_STOP1;
				end else begin
					n_ack = ack_inc[7:0];
				end
			end
			i2cee_pkg::P_RXLOW: n_phase = i2cee_pkg::P_RXHIGH;
			i2cee_pkg::P_RXHIGH: begin
				n_shifter = rx_shift;
				if (bit_inc >= 4'd8) begin
					n_bit   = 4'd0;
					n_phase = i2cee_pkg::P_MACKLOW;
				end else begin
					n_bit   = bit_inc;
					n_phase = i2cee_pkg::P_RXLOW;
				end
			end
			i2cee_pkg::P_MACKLOW: n_phase = i2cee_pkg::P_MACKHIGH;
			i2cee_pkg::P_MACKHIGH: begin
				n_byte  = byte_inc[LEN_W-1:0];
				n_phase = last_byte ? i2cee_pkg::P_STOP1 : i2cee_pkg::P_RXLOW;
			end
			i2cee_pkg::P_RECLOW: n_phase = i2cee_pkg::P_RECHIGH;
			i2cee_pkg::P_RECHIGH: begin
				if (bit_inc >= 4'd9) begin
					n_bit   = 4'd0;
					n_seg   = i2cee_pkg::SEG_ADDR;
					n_phase = i2cee_pkg::P_RS0;
				end else begin
					n_bit   = bit_inc;
					n_phase = i2cee_pkg::P_RECLOW;
				end
			end
			i2cee_pkg::P_STOP1: n_phase = i2cee_pkg::P_STOP2;
			i2cee_pkg::P_STOP2: n_phase = i2cee_pkg::P_STOP3;
			i2cee_pkg::P_STOP3: begin
				if (wait_go) begin
					n_pw    = cfg.write_wait_ticks;
					n_phase = i2cee_pkg::P_WAIT;
				end else begin
					n_phase = i2cee_pkg::P_IDLE;
				end
			end
			i2cee_pkg::P_WAIT: begin
				n_pw = pw_dec;
				if (pw_dec == 16'd0) begin
					n_phase = i2cee_pkg::P_IDLE;
				end
			end
			default: n_phase = i2cee_pkg::P_IDLE;
		endcase
	end

	// Bus levels and strobes for this tick.
	always_comb begin
		res = '0;
		res.scl_out  = 1'b1;
		res.sda_out  = 1'b1;
		res.busy_res = 1'b1;
		unique case (e_phase)
			i2cee_pkg::P_IDLE: res.busy_res = 1'b0;
			i2cee_pkg::P_START1: ;
			i2cee_pkg::P_START2: res.sda_out = 1'b0;
			i2cee_pkg::P_RS0: res.scl_out = 1'b0;
			i2cee_pkg::P_TXLOW: begin
				res.scl_out    = 1'b0;
				res.sda_out    = tx_byte[7];
				res.wdata_take = (e_bit == 4'd0) && (e_seg == i2cee_pkg::SEG_DATA);
			end
			i2cee_pkg::P_TXHIGH: res.sda_out = shifter_q[7];
			i2cee_pkg::P_ACKLOW: res.scl_out = 1'b0;
			i2cee_pkg::P_ACKHIGH: ;
			i2cee_pkg::P_RXLOW: res.scl_out = 1'b0;
			i2cee_pkg::P_RXHIGH: begin
				if (bit_inc >= 4'd8) begin
					res.rdata       = rx_shift;
					res.rdata_valid = 1'b1;
				end
			end
			i2cee_pkg::P_MACKLOW: begin
				res.scl_out = 1'b0;
				res.sda_out = last_byte;
			end
			i2cee_pkg::P_MACKHIGH: res.sda_out = last_byte;
			i2cee_pkg::P_RECLOW: res.scl_out = 1'b0;
			i2cee_pkg::P_RECHIGH: ;
			i2cee_pkg::P_STOP1: begin
				res.scl_out = 1'b0;
				res.sda_out = 1'b0;
			end
			i2cee_pkg::P_STOP2: res.sda_out = 1'b0;
			i2cee_pkg::P_STOP3: begin
				res.done_res = !wait_go;
				res.status   = !wait_go && e_failed;
			end
			i2cee_pkg::P_WAIT: res.done_res = (pw_dec == 16'd0);
			default: res.busy_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cee_pkg::P_IDLE;
			seg_q     <= i2cee_pkg::SEG_DEVW;
			mode_q    <= 2'd0;
			page_q    <= 1'b0;
			addr_q    <= 8'd0;
			len_q     <= '0;
			bit_q     <= 4'd0;
			byte_q    <= '0;
			ack_q     <= 8'd0;
			pw_q      <= 16'd0;
			shifter_q <= 8'd0;
			failed_q  <= 1'b0;
		end else if (step_en) begin
			phase_q   <= n_phase;
			seg_q     <= n_seg;
			mode_q    <= e_mode;
			page_q    <= e_page;
			addr_q    <= e_addr;
			len_q     <= e_len;
			bit_q     <= n_bit;
			byte_q    <= n_byte;
			ack_q     <= n_ack;
			pw_q      <= n_pw;
			shifter_q <= n_shifter;
			failed_q  <= n_failed;
		end
	end

endmodule

FILE: src/i2c_eeprom_master.sv
// A tick item is held in the input register, and its result item is registered into the output
// register when the sequencer steps; it is taken from there by the output handshake.
// Throughput: one tick item per clock unless the output stalls; one sequencer step per item.
// A stalled result is held in the output register while the input register keeps one more item.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and the registers
// to device code 40, ACK timeout 250 and write wait 2000.
module i2c_eeprom_master #(
	parameter int MAX_BURST = i2cee_pkg::MAX_BURST_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2cee_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_wdata,
	i2cee_if.sink                            cmd,
	i2cee_if.source                          res
);

	i2cee_pkg::cmd_t cmd_s1;
	i2cee_pkg::res_t res_s2, step_res;
	i2cee_pkg::cfg_t cfg;
	logic            vld_s1, vld_s2, adv;

	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || adv;
	assign res.valid = vld_s2;
	assign res.data  = res_s2;

	i2cee_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cee_seq #(.MAX_BURST(MAX_BURST)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (cmd_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (res.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (adv) begin
			res_s2 <= step_res;
		end
	end

endmodule

FILE: src/i2cee_chk.sv
`include "i2c_eeprom_master_macros.svh"

module i2cee_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input i2cee_pkg::res_t res_data
);

	`I2CEE_ASSERT(a_res_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_data)), "Stalled result item changed")
	`I2CEE_ASSERT_VLD(a_done_busy, clk, arst_n, res_valid, !res_data.done_res || res_data.busy_res, "Command finished while not busy")
	`I2CEE_ASSERT_VLD(a_status_done, clk, arst_n, res_valid, !res_data.status || res_data.done_res, "Failure status shown without done")
	`I2CEE_ASSERT_VLD(a_idle_bus, clk, arst_n, res_valid, res_data.busy_res || (res_data.scl_out && res_data.sda_out && !res_data.wdata_take && !res_data.rdata_valid), "Idle bus not released")
	`I2CEE_ASSERT_VLD(a_rx_high, clk, arst_n, res_valid, !res_data.rdata_valid || (res_data.scl_out && res_data.busy_res && res_data.sda_out), "Read byte completed outside a high clock phase")

endmodule

bind i2c_eeprom_master i2cee_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
